### hdl/segmentation_f1_scorer_core_macros.svh
// Assertion macros for the segmentation F1 scorer checker.
`ifndef SEGMENTATION_F1_SCORER_CORE_MACROS_SVH
`define SEGMENTATION_F1_SCORER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SF1S_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SF1S_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/sf1s_pkg.sv
// Shared types and constants for the segmentation F1 scorer.
package sf1s_pkg;

    localparam int COUNT_BITS = 22;
    localparam int PIX_BITS   = 8;
    localparam int Q_FRAC     = 15;
    localparam int SCORE_BITS = 16;
    localparam int SUM_BITS   = 19;
    localparam int NUM_BITS   = COUNT_BITS + 1;
    localparam int DEN_BITS   = COUNT_BITS + 2;
    localparam int ITER_BITS  = $clog2(Q_FRAC);

    localparam logic [PIX_BITS-1:0]   PIX_FG    = '0;
    localparam logic [PIX_BITS-1:0]   PIX_BG    = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
    localparam logic [ITER_BITS-1:0]  ITER_LAST = ITER_BITS'(Q_FRAC - 1);

    typedef enum logic [1:0] {
        ST_COUNT,
        ST_LOAD,
        ST_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic count;
        logic load;
        logic step;
        logic finish;
    } cmd_t;

endpackage

### hdl/sf1s_ctrl.sv
// Controller: pixel counting, divider sequencing and output handshake.
module sf1s_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           image_end,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output sf1s_pkg::cmd_t cmd
);
    import sf1s_pkg::*;

    state_t               state_reg, state_next;
    logic [ITER_BITS-1:0] iter_reg, iter_next;
    logic                 out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_COUNT;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        iter_next      = iter_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_COUNT:
            begin
                in_ready  = 1'b1;
                cmd.count = in_valid;
                if (in_valid && image_end)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                iter_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                if (iter_reg == ITER_LAST)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    iter_next = iter_reg + 1'b1;
                end
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_COUNT;
                end
            end
            default:
            begin
                state_next = ST_COUNT;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

### hdl/sf1s_datapath.sv
// Datapath: confusion counters, restoring divider, group sum, result register.
module sf1s_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  sf1s_pkg::cmd_t                       cmd,
    input  logic [sf1s_pkg::PIX_BITS-1:0]        result_pixel,
    input  logic [sf1s_pkg::PIX_BITS-1:0]        target_pixel,
    input  logic                                 image_end,
    input  logic                                 group_end,
    output logic [sf1s_pkg::SCORE_BITS-1:0]      image_score,
    output logic [sf1s_pkg::SUM_BITS-1:0]        total_score,
    output logic                                 is_group_end
);
    import sf1s_pkg::*;

    logic [COUNT_BITS-1:0] tp_reg, tp_next;
    logic [COUNT_BITS-1:0] fp_reg, fp_next;
    logic [COUNT_BITS-1:0] fn_reg, fn_next;
    logic [SUM_BITS-1:0]   sum_reg, sum_next;
    logic                  grp_reg, grp_next;
    logic [DEN_BITS-1:0]   rem_reg, rem_next;
    logic [DEN_BITS-1:0]   den_reg, den_next;
    logic [Q_FRAC-1:0]     quo_reg, quo_next;
    logic [SCORE_BITS-1:0] image_score_reg, image_score_next;
    logic [SUM_BITS-1:0]   total_score_reg, total_score_next;
    logic                  is_group_end_reg, is_group_end_next;

    logic                  is_tp, is_fp, is_fn;
    logic [COUNT_BITS-1:0] tp_min, fp_min, fn_min;
    logic [NUM_BITS-1:0]   num;
    logic [DEN_BITS:0]     rem_shift;
    logic [DEN_BITS:0]     rem_diff;
    logic [SUM_BITS:0]     sum_wide;
    logic [SUM_BITS-1:0]   sum_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tp_reg  <= '0;
            fp_reg  <= '0;
            fn_reg  <= '0;
            sum_reg <= '0;
        end
        else
        begin
            tp_reg  <= tp_next;
            fp_reg  <= fp_next;
            fn_reg  <= fn_next;
            sum_reg <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg          <= grp_next;
        rem_reg          <= rem_next;
        den_reg          <= den_next;
        quo_reg          <= quo_next;
        image_score_reg  <= image_score_next;
        total_score_reg  <= total_score_next;
        is_group_end_reg <= is_group_end_next;
    end

    always_comb
    begin
        is_tp = (result_pixel == PIX_FG) && (target_pixel == PIX_FG);
        is_fp = (result_pixel == PIX_FG) && (target_pixel == PIX_BG);
        is_fn = (result_pixel == PIX_BG) && (target_pixel == PIX_FG);

        tp_min = (tp_reg == '0) ? COUNT_BITS'(1) : tp_reg;
        fp_min = (fp_reg == '0) ? COUNT_BITS'(1) : fp_reg;
        fn_min = (fn_reg == '0) ? COUNT_BITS'(1) : fn_reg;
        num    = {tp_min, 1'b0};

        rem_shift = {rem_reg, 1'b0};
        rem_diff  = rem_shift - {1'b0, den_reg};

        sum_wide = {1'b0, sum_reg} + (SUM_BITS + 1)'(quo_reg);
        sum_sat  = sum_wide[SUM_BITS] ? SUM_MAX : sum_wide[SUM_BITS-1:0];

        tp_next           = tp_reg;
        fp_next           = fp_reg;
        fn_next           = fn_reg;
        sum_next          = sum_reg;
        grp_next          = grp_reg;
        rem_next          = rem_reg;
        den_next          = den_reg;
        quo_next          = quo_reg;
        image_score_next  = image_score_reg;
        total_score_next  = total_score_reg;
        is_group_end_next = is_group_end_reg;

        if (cmd.count)
        begin
            if (is_tp && (tp_reg != COUNT_MAX))
            begin
                tp_next = tp_reg + 1'b1;
            end
            if (is_fp && (fp_reg != COUNT_MAX))
            begin
                fp_next = fp_reg + 1'b1;
            end
            if (is_fn && (fn_reg != COUNT_MAX))
            begin
                fn_next = fn_reg + 1'b1;
            end
            if (image_end)
            begin
                grp_next = group_end;
            end
        end

        // num < den always, so the quotient is Q_FRAC fraction bits only
        if (cmd.load)
        begin
            rem_next = DEN_BITS'(num);
            den_next = DEN_BITS'(num) + DEN_BITS'(fp_min) + DEN_BITS'(fn_min);
            quo_next = '0;
            tp_next  = '0;
            fp_next  = '0;
            fn_next  = '0;
        end

        if (cmd.step)
        begin
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_next = rem_diff[DEN_BITS-1:0];
                quo_next = {quo_reg[Q_FRAC-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_shift[DEN_BITS-1:0];
                quo_next = {quo_reg[Q_FRAC-2:0], 1'b0};
            end
        end

        if (cmd.finish)
        begin
            image_score_next = SCORE_BITS'(quo_reg);
            if (grp_reg)
            begin
                total_score_next  = sum_sat;
                is_group_end_next = 1'b1;
                sum_next          = '0;
            end
            else
            begin
                total_score_next  = '0;
                is_group_end_next = 1'b0;
                sum_next          = sum_sat;
            end
        end
    end

    assign image_score  = image_score_reg;
    assign total_score  = total_score_reg;
    assign is_group_end = is_group_end_reg;

endmodule

### hdl/segmentation_f1_scorer_core.sv
// Top level of the segmentation F1 scorer: controller plus datapath.
//
//  beat     | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  pixel in | in_valid / in_ready  | result_pixel, target_pixel, image_end, group_end
//  score out| out_valid / out_ready| image_score, total_score, is_group_end
//
// Pixels are taken one per cycle while in_ready is high.
// After an image_end beat in_ready stays low while the block forms the
// denominator, runs the one-bit-per-cycle restoring divider and writes the
// result register. The result write waits while a previous score is not taken.
// Reset clears the counters, the group sum, the controller state and out_valid.
module segmentation_f1_scorer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [sf1s_pkg::PIX_BITS-1:0]        result_pixel,
    input  logic [sf1s_pkg::PIX_BITS-1:0]        target_pixel,
    input  logic                                 image_end,
    input  logic                                 group_end,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [sf1s_pkg::SCORE_BITS-1:0]      image_score,
    output logic [sf1s_pkg::SUM_BITS-1:0]        total_score,
    output logic                                 is_group_end
);
    import sf1s_pkg::*;

    cmd_t cmd;

    sf1s_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .image_end (image_end),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sf1s_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .result_pixel (result_pixel),
        .target_pixel (target_pixel),
        .image_end    (image_end),
        .group_end    (group_end),
        .image_score  (image_score),
        .total_score  (total_score),
        .is_group_end (is_group_end)
    );

endmodule

### hdl/sf1s_checker.sv
// Port-level checker for the segmentation F1 scorer, bound to the top level.
`include "segmentation_f1_scorer_core_macros.svh"

module sf1s_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 image_end,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic [sf1s_pkg::SCORE_BITS-1:0]      image_score,
    input logic [sf1s_pkg::SUM_BITS-1:0]        total_score,
    input logic                                 is_group_end
);
    import sf1s_pkg::*;

    logic score_below_one;

    assign score_below_one = !image_score[SCORE_BITS-1];

    `SF1S_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(image_score), "score beat dropped or changed while stalled")
    `SF1S_ASSERT_NOW(a_total_zero, out_valid && !is_group_end, total_score == '0, "total_score nonzero outside group end")
    `SF1S_ASSERT_NOW(a_score_range, out_valid, score_below_one, "image_score reached 1.0")
    `SF1S_ASSERT_NEXT(a_busy_after_end, in_valid && in_ready && image_end, !in_ready, "pixel taken while score is computed")

endmodule

bind segmentation_f1_scorer_core sf1s_checker u_sf1s_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .image_end    (image_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .image_score  (image_score),
    .total_score  (total_score),
    .is_group_end (is_group_end)
);
